// ===== src/fgfs_pkg.sv =====
// Shared types, codes and constants of the frontier grid flood search block.
package fgfs_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 13;

  localparam logic [CFG_W-1:0]   GRID_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'h1FFF;

  localparam int          NUM_DIRS = 8;
  localparam logic [2:0]  LAST_DIR = 3'(NUM_DIRS - 1);

  // Neighbor offsets, in the order the walk visits them.
  localparam logic signed [1:0] STEP_DX [NUM_DIRS] =
    '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_DY [NUM_DIRS] =
    '{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [7:0] cell_x;
    logic signed [7:0] cell_y;
    logic signed [7:0] occupancy;
  } item_t;

  typedef struct packed {
    logic               is_frontier;
    logic               was_reached;
    logic [COUNT_W-1:0] frontier_count;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
  } grid_cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_status_t;

endpackage

// ===== src/fgfs_if.sv =====
// Handshake channel interfaces of the frontier grid flood search block.
interface fgfs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [7:0] cell_x;
  logic signed [7:0] cell_y;
  logic signed [7:0] occupancy;

  modport source (output valid, command, cell_x, cell_y, occupancy, input ready);
  modport sink (input valid, command, cell_x, cell_y, occupancy, output ready);
endinterface

interface fgfs_out_if;
  import fgfs_pkg::*;
  logic               valid;
  logic               ready;
  logic               is_frontier;
  logic               was_reached;
  logic [COUNT_W-1:0] frontier_count;

  modport source (output valid, is_frontier, was_reached, frontier_count, input ready);
  modport sink (input valid, is_frontier, was_reached, frontier_count, output ready);
endinterface

interface fgfs_cfg_if;
  import fgfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/fgfs_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
module fgfs_ram #(
  parameter int Width = 1,
  parameter int Depth = 2,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fgfs_engine.sv =====
// Command sequencer and breadth-first frontier walk over the class, mark and queue memories.
module fgfs_engine #(
  parameter int MAX_WIDTH  = fgfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fgfs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fgfs_pkg::grid_cfg_t    cfg_i,
  input  logic                   accept_i,
  input  fgfs_pkg::item_t        item_i,
  output fgfs_pkg::eng_status_t  status_o,
  output fgfs_pkg::result_t      result_o
);
  import fgfs_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int QW    = XW + YW;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int QCW   = $clog2(CELLS + 1);
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int CW    = (MW + 2 > 9) ? MW + 2 : 9;

  localparam int MARK_VIS = 0;
  localparam int MARK_FR  = 1;

  localparam logic [1:0] CLS_FREE = 2'd0;
  localparam logic [1:0] CLS_OCC  = 2'd1;
  localparam logic [1:0] CLS_UNK  = 2'd2;

  localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;
  localparam logic signed [7:0] OCC_FREE    = 8'sd0;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_POP, ST_POP_W,
    ST_NB, ST_NB_W, ST_UNK, ST_UNK_W, ST_DONE
  } state_e;

  function automatic logic in_grid(coord_t x, coord_t y, coord_t gw, coord_t gh);
    return (x >= 0) && (y >= 0) &&
           (x < coord_t'(MAX_WIDTH)) && (y < coord_t'(MAX_HEIGHT)) &&
           (x < gw) && (y < gh);
  endfunction

  function automatic logic [AW-1:0] cell_addr(coord_t x, coord_t y);
    logic [AW-1:0] ya;
    ya = AW'(y[YW-1:0]);
    return AW'(ya * AW'(MAX_WIDTH)) + AW'(x[XW-1:0]);
  endfunction

  function automatic logic [1:0] class_of(logic signed [7:0] occ);
    if (occ == OCC_UNKNOWN) begin
      return CLS_UNK;
    end else if (occ == OCC_FREE) begin
      return CLS_FREE;
    end
    return CLS_OCC;
  endfunction

  state_e             state_q;
  logic               init_q;
  logic [AW-1:0]      clr_q;
  coord_t             sx_q, sy_q, cur_x_q, cur_y_q, nb_x_q, nb_y_q;
  logic [2:0]         k_q, j_q;
  logic [QCW-1:0]     head_q, tail_q;
  logic [COUNT_W-1:0] total_q;
  logic               res_v_q, rd_ok_q;
  logic               res_v_d;

  coord_t  gw, gh, it_x, it_y, n_x, n_y, m_x, m_y;
  logic    it_in_store, n_in, m_in, start_in, q_has, is_unk, room;
  logic    fin_plain, fin_front;

  logic          cls_we, cls_re;
  logic [AW-1:0] cls_waddr, cls_raddr;
  logic [1:0]    cls_wdata, cls_rdata;
  logic          mrk_we, mrk_re;
  logic [AW-1:0] mrk_waddr, mrk_raddr;
  logic [1:0]    mrk_wdata, mrk_rdata;
  logic          q_we, q_re;
  logic [AW-1:0] q_waddr, q_raddr;
  logic [QW-1:0] q_wdata, q_rdata;

  always_comb begin
    gw   = coord_t'(cfg_i.grid_width);
    gh   = coord_t'(cfg_i.grid_height);
    it_x = coord_t'($signed(item_i.cell_x));
    it_y = coord_t'($signed(item_i.cell_y));
    it_in_store = (it_x >= 0) && (it_y >= 0) &&
                  (it_x < coord_t'(MAX_WIDTH)) && (it_y < coord_t'(MAX_HEIGHT));
    n_x = cur_x_q + coord_t'(STEP_DX[k_q]);
    n_y = cur_y_q + coord_t'(STEP_DY[k_q]);
    m_x = nb_x_q + coord_t'(STEP_DX[j_q]);
    m_y = nb_y_q + coord_t'(STEP_DY[j_q]);
    n_in     = in_grid(n_x, n_y, gw, gh);
    m_in     = in_grid(m_x, m_y, gw, gh);
    start_in = in_grid(sx_q, sy_q, gw, gh);
    q_has  = (head_q < tail_q) && (head_q < QCW'(CELLS));
    room   = tail_q < QCW'(CELLS);
    is_unk = cls_rdata == CLS_UNK;
    // A candidate with no unknown neighbor is finished either on an out-of-grid last probe
    // or on a last probe that read a known class.
    fin_plain = ((state_q == ST_UNK) && !m_in && (j_q == LAST_DIR)) ||
                ((state_q == ST_UNK_W) && !is_unk && (j_q == LAST_DIR));
    fin_front = (state_q == ST_UNK_W) && is_unk;
  end

  // Every command except a start answers right away; a start answers when the walk ends.
  assign res_v_d = (state_q == ST_DONE) ||
                   ((state_q == ST_IDLE) && accept_i && (item_i.command != CMD_START));

  always_comb begin
    cls_we    = accept_i && (item_i.command == CMD_LOAD) && it_in_store;
    cls_waddr = cell_addr(it_x, it_y);
    cls_wdata = class_of($signed(item_i.occupancy));
    cls_re    = 1'b0;
    cls_raddr = cell_addr(n_x, n_y);
    mrk_we    = 1'b0;
    mrk_waddr = cell_addr(nb_x_q, nb_y_q);
    mrk_wdata = 2'b00;
    mrk_re    = 1'b0;
    mrk_raddr = cell_addr(n_x, n_y);
    q_we      = 1'b0;
    q_waddr   = tail_q[AW-1:0];
    q_wdata   = {nb_y_q[YW-1:0], nb_x_q[XW-1:0]};
    q_re      = 1'b0;
    q_raddr   = head_q[AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        mrk_we    = 1'b1;
        mrk_waddr = clr_q;
      end
      ST_IDLE: begin
        mrk_re    = accept_i && (item_i.command == CMD_READ) && it_in_store;
        mrk_raddr = cell_addr(it_x, it_y);
      end
      ST_START: begin
        mrk_we    = start_in;
        mrk_waddr = cell_addr(sx_q, sy_q);
        mrk_wdata[MARK_VIS] = 1'b1;
        q_we      = start_in;
        q_wdata   = {sy_q[YW-1:0], sx_q[XW-1:0]};
      end
      ST_POP: begin
        q_re = q_has;
      end
      ST_NB: begin
        cls_re = n_in;
        mrk_re = n_in;
      end
      ST_UNK, ST_UNK_W: begin
        cls_re    = (state_q == ST_UNK) && m_in;
        cls_raddr = cell_addr(m_x, m_y);
        mrk_we    = fin_plain || fin_front;
        mrk_wdata = {fin_front, 1'b1};
        q_we      = fin_plain && room;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      init_q  <= 1'b1;
      clr_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      nb_x_q  <= '0;
      nb_y_q  <= '0;
      k_q     <= '0;
      j_q     <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      total_q <= '0;
      res_v_q <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      res_v_q <= res_v_d;
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == AW'(CELLS - 1)) begin
            clr_q   <= '0;
            init_q  <= 1'b0;
            state_q <= init_q ? ST_IDLE : ST_START;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept_i) begin
            unique case (item_i.command)
              CMD_START: begin
                sx_q    <= it_x;
                sy_q    <= it_y;
                total_q <= '0;
                head_q  <= '0;
                tail_q  <= '0;
                state_q <= ST_CLEAR;
              end
              CMD_READ: begin
                rd_ok_q <= it_in_store;
              end
              default: begin
                rd_ok_q <= 1'b0;
              end
            endcase
          end
        end
        ST_START: begin
          if (start_in) begin
            tail_q  <= QCW'(1);
            state_q <= ST_POP;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_POP: begin
          if (q_has) begin
            head_q  <= head_q + QCW'(1);
            state_q <= ST_POP_W;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_POP_W: begin
          cur_x_q <= coord_t'(q_rdata[XW-1:0]);
          cur_y_q <= coord_t'(q_rdata[QW-1:XW]);
          k_q     <= '0;
          state_q <= ST_NB;
        end
        ST_NB: begin
          nb_x_q <= n_x;
          nb_y_q <= n_y;
          if (n_in) begin
            state_q <= ST_NB_W;
          end else if (k_q == LAST_DIR) begin
            state_q <= ST_POP;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_NB_W: begin
          if (mrk_rdata[MARK_VIS] || (cls_rdata != CLS_FREE)) begin
            if (k_q == LAST_DIR) begin
              state_q <= ST_POP;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_NB;
            end
          end else begin
            j_q     <= '0;
            state_q <= ST_UNK;
          end
        end
        ST_UNK, ST_UNK_W: begin
          if (fin_plain || fin_front) begin
            if (fin_plain && room) begin
              tail_q <= tail_q + QCW'(1);
            end
            if (fin_front && (total_q != COUNT_MAX)) begin
              total_q <= total_q + COUNT_W'(1);
            end
            if (k_q == LAST_DIR) begin
              state_q <= ST_POP;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_NB;
            end
          end else if ((state_q == ST_UNK) && m_in) begin
            state_q <= ST_UNK_W;
          end else begin
            j_q     <= j_q + 3'd1;
            state_q <= ST_UNK;
          end
        end
        ST_DONE: begin
          rd_ok_q <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  fgfs_ram #(.Width(2), .Depth(CELLS), .AddrW(AW)) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (cls_we),
    .waddr_i (cls_waddr),
    .wdata_i (cls_wdata),
    .re_i    (cls_re),
    .raddr_i (cls_raddr),
    .rdata_o (cls_rdata)
  );

  fgfs_ram #(.Width(2), .Depth(CELLS), .AddrW(AW)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mrk_we),
    .waddr_i (mrk_waddr),
    .wdata_i (mrk_wdata),
    .re_i    (mrk_re),
    .raddr_i (mrk_raddr),
    .rdata_o (mrk_rdata)
  );

  fgfs_ram #(.Width(QW), .Depth(CELLS), .AddrW(AW)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign status_o.idle      = state_q == ST_IDLE;
  assign status_o.res_valid = res_v_q;

  assign result_o.is_frontier    = rd_ok_q & mrk_rdata[MARK_FR];
  assign result_o.was_reached    = rd_ok_q & mrk_rdata[MARK_VIS];
  assign result_o.frontier_count = total_q;

`ifndef SYNTHESIS
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= QCW'(CELLS))
    else $error("queue tail beyond cell count");
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> ($past(state_q) == ST_DONE) || $past(accept_i))
    else $error("result without a finished command");
`endif

endmodule

// ===== src/frontier_grid_flood_search.sv =====
// Top level of the frontier grid flood search: config registers, engine and result buffer.
//
//   Channel  Dir  Beat contents
//   cfg_i    in   index (0 grid_width, 1 grid_height), data
//   in_i     in   command, cell_x, cell_y, occupancy
//   out_o    out  is_frontier, was_reached, frontier_count
//
// Loads, reads and unused commands leave the engine idle; the result is buffered in the next cycle.
// A start sweeps all MAX_WIDTH*MAX_HEIGHT cells of the mark memory and seeds the queue, then
// dequeues cells one by one, probes each in-grid neighbor and the neighbors of each candidate,
// and answers once it sees the empty queue.
// After reset the same sweep clears the marks; in_i is not ready meanwhile, cfg_i always is.
// A two-entry result buffer lets work go on while out_o stalls; the engine leaves its idle
// state for the walk, so in_i holds ready low during a search.
module frontier_grid_flood_search #(
  parameter int MAX_WIDTH  = fgfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fgfs_pkg::DEF_MAX_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fgfs_cfg_if.sink   cfg_i,
  fgfs_in_if.sink    in_i,
  fgfs_out_if.source out_o
);
  import fgfs_pkg::*;

  localparam int OutDepth = 2;
  localparam int PW       = $clog2(OutDepth);
  localparam int CNTW     = $clog2(OutDepth + 1);
  localparam int UW       = CNTW + 1;

  grid_cfg_t   cfg_q;
  item_t       item;
  eng_status_t status;
  result_t     result;
  result_t     fifo_q [OutDepth];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            accept, push, pop;
  logic [UW-1:0]   used;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= GRID_RESET;
      cfg_q.grid_height <= GRID_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_i.data;
        CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign item.command   = in_i.command;
  assign item.cell_x    = in_i.cell_x;
  assign item.cell_y    = in_i.cell_y;
  assign item.occupancy = in_i.occupancy;

  assign push   = status.res_valid;
  assign pop    = out_o.valid && out_o.ready;
  assign accept = in_i.valid && in_i.ready;

  // An item is taken only when its result is sure to find a buffer slot.
  assign used = UW'(cnt_q) + UW'(push);
  assign in_i.ready = status.idle && (used < (UW'(OutDepth) + UW'(pop)));

  fgfs_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .item_i   (item),
    .status_o (status),
    .result_o (result)
  );

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= CNTW'(cnt_q + CNTW'(push) - CNTW'(pop));
    end
  end

  assign out_o.valid          = cnt_q != '0;
  assign out_o.is_frontier    = fifo_q[rd_ptr_q].is_frontier;
  assign out_o.was_reached    = fifo_q[rd_ptr_q].was_reached;
  assign out_o.frontier_count = fifo_q[rd_ptr_q].frontier_count;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q < CNTW'(OutDepth)) || pop)
    else $error("result buffer overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(OutDepth))
    else $error("result buffer count out of range");
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item.command != CMD_START)) |=> push)
    else $error("single-cycle command gave no result");
`endif

endmodule

// ===== bench/fgfs_checker.sv =====
// Checker for the frontier grid flood search: tracks the grid, predicts every result, compares.
`timescale 1ns / 100ps

module fgfs_checker
  import fgfs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fgfs_cfg_if  cfg_mon,
  fgfs_in_if   in_mon,
  fgfs_out_if  out_mon,
  output int   fail_count_o,
  output int   awaiting_o
);

  localparam int SIDE_X       = DEF_MAX_WIDTH;
  localparam int SIDE_Y       = DEF_MAX_HEIGHT;
  localparam int CELLS        = SIDE_X * SIDE_Y;
  localparam int REPORT_LIMIT = 10;
  localparam int OFS_X [8]    = '{0, 0, 1, -1, 1, 1, -1, -1};
  localparam int OFS_Y [8]    = '{1, -1, 0, 0, 1, -1, 1, -1};

  typedef enum logic [1:0] {
    KIND_FREE,
    KIND_OCCUPIED,
    KIND_UNKNOWN
  } cell_kind_e;

  cell_kind_e         cell_kind [CELLS];
  bit                 reached_mark [CELLS];
  bit                 frontier_mark [CELLS];
  logic [COUNT_W-1:0] frontier_tally = '0;
  logic [CFG_W-1:0]   cols_reg = GRID_RESET;
  logic [CFG_W-1:0]   rows_reg = GRID_RESET;
  result_t            marks_q [$];
  int                 fail_total = 0;
  int                 awaiting_cnt = 0;

  assign fail_count_o = fail_total;
  assign awaiting_o   = awaiting_cnt;

  function automatic int used_cols();
    return (cols_reg > SIDE_X) ? SIDE_X : int'(cols_reg);
  endfunction

  function automatic int used_rows();
    return (rows_reg > SIDE_Y) ? SIDE_Y : int'(rows_reg);
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < used_cols() && y < used_rows();
  endfunction

  function automatic bit in_store(int x, int y);
    return x >= 0 && y >= 0 && x < SIDE_X && y < SIDE_Y;
  endfunction

  function automatic bit borders_unknown(int x, int y);
    int k;
    for (k = 0; k < 8; k++) begin
      if (on_grid(x + OFS_X[k], y + OFS_Y[k]) &&
          cell_kind[(y + OFS_Y[k]) * SIDE_X + x + OFS_X[k]] == KIND_UNKNOWN) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Breadth-first walk; frontier cells are marked but never expanded.
  function automatic void flood_from(int sx, int sy);
    int open_cells [$];
    int cur, cx, cy, nx, ny, k, i, a;
    for (i = 0; i < CELLS; i++) begin
      reached_mark[i]  = 1'b0;
      frontier_mark[i] = 1'b0;
    end
    frontier_tally = '0;
    if (!on_grid(sx, sy)) return;
    reached_mark[sy * SIDE_X + sx] = 1'b1;
    open_cells = {open_cells, sy * SIDE_X + sx};
    while (open_cells.size() > 0) begin
      cur = open_cells.pop_front();
      cx  = cur % SIDE_X;
      cy  = cur / SIDE_X;
      for (k = 0; k < 8; k++) begin
        nx = cx + OFS_X[k];
        ny = cy + OFS_Y[k];
        if (on_grid(nx, ny)) begin
          a = ny * SIDE_X + nx;
          if (!reached_mark[a] && cell_kind[a] == KIND_FREE) begin
            reached_mark[a] = 1'b1;
            if (borders_unknown(nx, ny)) begin
              frontier_mark[a] = 1'b1;
              if (frontier_tally != COUNT_MAX) frontier_tally = frontier_tally + 1'b1;
            end else begin
              open_cells = {open_cells, a};
            end
          end
        end
      end
    end
  endfunction

  function automatic result_t predict_marks(item_t beat);
    result_t res;
    int      x, y, occ, a;
    x   = int'($signed(beat.cell_x));
    y   = int'($signed(beat.cell_y));
    occ = int'($signed(beat.occupancy));
    a   = y * SIDE_X + x;
    res = '0;
    case (beat.command)
      CMD_LOAD: begin
        if (in_store(x, y)) begin
          cell_kind[a] = (occ == -1) ? KIND_UNKNOWN : (occ == 0) ? KIND_FREE : KIND_OCCUPIED;
        end
      end
      CMD_START: flood_from(x, y);
      CMD_READ: begin
        if (in_store(x, y)) begin
          res.is_frontier = frontier_mark[a];
          res.was_reached = reached_mark[a];
        end
      end
      default: ;
    endcase
    res.frontier_count = frontier_tally;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t expect_res;
    item_t   beat;
    int      i;
    if (!rst_ni) begin
      for (i = 0; i < CELLS; i++) begin
        reached_mark[i]  = 1'b0;
        frontier_mark[i] = 1'b0;
      end
      frontier_tally = '0;
      cols_reg       = GRID_RESET;
      rows_reg       = GRID_RESET;
      marks_q.delete();
      awaiting_cnt <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_GRID_WIDTH:  cols_reg = cfg_mon.data;
          CFG_GRID_HEIGHT: rows_reg = cfg_mon.data;
          default: ;
        endcase
      end
      // Results are retired before new expectations are queued, so a stray beat is caught.
      if (out_mon.valid && out_mon.ready) begin
        if (marks_q.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT) begin
            $display("%0t: result beat with nothing expected: frontier %0b reached %0b count %0d",
                     $time, out_mon.is_frontier, out_mon.was_reached, out_mon.frontier_count);
          end
        end else begin
          want = marks_q.pop_front();
          if (out_mon.is_frontier !== want.is_frontier ||
              out_mon.was_reached !== want.was_reached ||
              out_mon.frontier_count !== want.frontier_count) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT) begin
              $display("%0t: result mismatch: frontier exp %0b got %0b, reached exp %0b got %0b",
                       $time, want.is_frontier, out_mon.is_frontier,
                       want.was_reached, out_mon.was_reached);
              $display("%0t:   frontier count exp %0d got %0d",
                       $time, want.frontier_count, out_mon.frontier_count);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        beat = '{in_mon.command, in_mon.cell_x, in_mon.cell_y, in_mon.occupancy};
        expect_res = predict_marks(beat);
        marks_q = {marks_q, expect_res};
      end
      awaiting_cnt <= marks_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the frontier grid flood search testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import fgfs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int GRID_SIDE      = DEF_MAX_WIDTH;
  localparam int STORE_CELLS    = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LIMIT_NS       = 10_000_000;
  localparam int NUM_PHASES     = 14;
  localparam int NUM_FIXED      = 8;
  localparam int RAND_PER_PHASE = 35;
  localparam int FILL_MAX       = 256;
  localparam int FIXED_COLS [NUM_FIXED] = '{1, 64, 1, 127, 2, 0, 9, 64};
  localparam int FIXED_ROWS [NUM_FIXED] = '{1, 1, 64, 2, 127, 9, 0, 64};
  localparam int PCT_CHOICES [3] = '{0, 20, 40};
  localparam int UNK_CHOICES [3] = '{2, 8, 25};
  localparam int DEMO_OCC [9] = '{0, 0, -1, 0, -128, 0, 0, 0, 0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic take_ok = 1'b0;
  int   fail_count;
  int   awaiting;

  // Stimulus knobs, changed between phases.
  bit quiet     = 1'b0;
  int idle_pct  = 0;
  int stall_pct = 0;
  int unk_pct   = 8;
  int stall_left = 0;
  int grid_cols = GRID_SIDE;
  int grid_rows = GRID_SIDE;
  bit cell_loaded [STORE_CELLS];

  fgfs_cfg_if cfg_bus ();
  fgfs_in_if  cell_bus ();
  fgfs_out_if mark_bus ();

  assign mark_bus.ready = take_ok;

  frontier_grid_flood_search u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (cell_bus),
    .out_o  (mark_bus)
  );

  fgfs_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .in_mon       (cell_bus),
    .out_mon      (mark_bus),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side back-pressure comes in bursts of random length.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      take_ok    <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      take_ok    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      take_ok    <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      take_ok <= 1'b1;
    end
  end

  function automatic int rand_s8();
    logic [7:0] b;
    b = 8'($urandom);
    return int'($signed(b));
  endfunction

  function automatic int rand_occupancy();
    int r;
    r = $urandom_range(0, 99);
    if (r < unk_pct) return -1;
    if (r < unk_pct + 65) return 0;
    return rand_s8();
  endfunction

  function automatic int grid_col();
    if (grid_cols > 0) return $urandom_range(0, grid_cols - 1);
    return $urandom_range(0, GRID_SIDE - 1);
  endfunction

  function automatic int grid_row();
    if (grid_rows > 0) return $urandom_range(0, grid_rows - 1);
    return $urandom_range(0, GRID_SIDE - 1);
  endfunction

  // A walk may only look at cells that were loaded, so starts inside wait for a full grid.
  function automatic bit grid_ready();
    int x, y;
    for (y = 0; y < grid_rows; y++) begin
      for (x = 0; x < grid_cols; x++) begin
        if (!cell_loaded[y * GRID_SIDE + x]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_item(logic [1:0] cmd, int x, int y, int occ);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      cell_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_bus.valid     <= 1'b1;
    cell_bus.command   <= cmd;
    cell_bus.cell_x    <= 8'(x);
    cell_bus.cell_y    <= 8'(y);
    cell_bus.occupancy <= 8'(occ);
    do @(posedge clk_i); while (!cell_bus.ready);
    if (cmd == CMD_LOAD && x >= 0 && y >= 0 && x < GRID_SIDE && y < GRID_SIDE) begin
      cell_loaded[y * GRID_SIDE + x] = 1'b1;
    end
  endtask

  // Stops the input side and waits until every result has come back.
  task automatic drain();
    cell_bus.valid <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_GRID_WIDTH;
    cfg_bus.data  <= cols;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.index <= CFG_GRID_HEIGHT;
    cfg_bus.data  <= rows;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    grid_cols = (cols > GRID_SIDE) ? GRID_SIDE : int'(cols);
    grid_rows = (rows > GRID_SIDE) ? GRID_SIDE : int'(rows);
  endtask

  initial begin
    int phase, pick, sx, sy, cx, cy, i;
    logic [CFG_W-1:0] cols, rows;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_GRID_WIDTH;
    cfg_bus.data       = '0;
    cell_bus.valid     = 1'b0;
    cell_bus.command   = CMD_LOAD;
    cell_bus.cell_x    = '0;
    cell_bus.cell_y    = '0;
    cell_bus.occupancy = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Loads outside the store are dropped, reads there return clear marks.
    send_item(CMD_LOAD, -128, 0, 0);
    send_item(CMD_LOAD, 0, 127, -1);
    send_item(CMD_LOAD, 64, 63, 127);
    send_item(CMD_READ, 127, -128, 0);
    send_item(CMD_UNUSED, -1, -1, -1);
    send_item(CMD_START, -1, 0, 0);
    send_item(CMD_START, 0, 64, 0);
    send_item(CMD_READ, 0, 0, 0);

    // A 3x3 grid with an occupied start cell in the middle and one unknown corner.
    set_grid(7'd3, 7'd3);
    for (i = 0; i < 9; i++) send_item(CMD_LOAD, i % 3, i / 3, DEMO_OCC[i]);
    send_item(CMD_START, 1, 1, 0);
    send_item(CMD_READ, 2, 0, 0);
    send_item(CMD_READ, 1, 0, 0);
    send_item(CMD_READ, 1, 1, 0);
    send_item(CMD_READ, 2, 2, 0);

    // Shrinking the grid must not disturb the marks of the last search.
    set_grid(7'd1, 7'd1);
    send_item(CMD_READ, 2, 1, 0);
    send_item(CMD_READ, 0, 1, 0);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < NUM_FIXED) begin
        cols = 7'(FIXED_COLS[phase]);
        rows = 7'(FIXED_ROWS[phase]);
      end else begin
        cols = 7'($urandom_range(1, 12));
        rows = 7'($urandom_range(1, 12));
      end
      quiet     = (phase == NUM_PHASES - 1);
      idle_pct  = PCT_CHOICES[$urandom_range(0, 2)];
      stall_pct = PCT_CHOICES[$urandom_range(0, 2)];
      unk_pct   = UNK_CHOICES[$urandom_range(0, 2)];
      set_grid(cols, rows);

      if (grid_cols * grid_rows <= FILL_MAX) begin
        for (cy = 0; cy < grid_rows; cy++) begin
          for (cx = 0; cx < grid_cols; cx++) begin
            if ($urandom_range(0, 9) == 0) send_item(CMD_READ, rand_s8(), rand_s8(), rand_s8());
            send_item(CMD_LOAD, cx, cy, rand_occupancy());
          end
        end
      end

      repeat (RAND_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
          if ($urandom_range(0, 6) != 0) send_item(CMD_LOAD, grid_col(), grid_row(), rand_occupancy());
          else send_item(CMD_LOAD, rand_s8(), rand_s8(), rand_s8());
        end else if (pick < 90) begin
          if ($urandom_range(0, 4) != 0) send_item(CMD_READ, grid_col(), grid_row(), rand_s8());
          else send_item(CMD_READ, rand_s8(), rand_s8(), rand_s8());
        end else if (pick < 95) begin
          if (grid_ready() && $urandom_range(0, 5) != 0) begin
            send_item(CMD_START, grid_col(), grid_row(), rand_s8());
          end else begin
            case ($urandom_range(0, 2))
              0: begin
                sx = -int'($urandom_range(1, 128));
                sy = rand_s8();
              end
              1: begin
                sx = grid_cols + int'($urandom_range(0, 127 - grid_cols));
                sy = rand_s8();
              end
              default: begin
                sx = rand_s8();
                sy = grid_rows + int'($urandom_range(0, 127 - grid_rows));
              end
            endcase
            send_item(CMD_START, sx, sy, rand_s8());
          end
        end else begin
          send_item(CMD_UNUSED, rand_s8(), rand_s8(), rand_s8());
        end
      end
    end

    drain();
    if (fail_count == 0 && awaiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
